/* hdl/mqd_pkg.sv */
package mqd_pkg;

  localparam int unsigned MaxSegmentBytes = 4096;
  localparam int unsigned NumContexts     = 19;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_INIT   = 2'd2,
    FUNC_DECODE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_RD0,
    S_RD1,
    S_APPLY,
    S_DEC,
    S_REN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic clear;
    logic append;
    logic init_regs;
    logic rd_next;
    logic capture_b0;
    logic apply;
    logic apply_init;
    logic decode;
    logic shift;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cx_ok;
    logic dec_renorm;
    logic bc_zero;
    logic shift_done;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic [15:0] qe;
    logic [5:0]  next_mps;
    logic [5:0]  next_lps;
    logic        flip;
  } prob_row_t;

  function automatic prob_row_t prob_row(input logic [5:0] row);
    prob_row_t r;
    r = '{16'h5601, 6'd46, 6'd46, 1'b0};
    unique case (row)
      6'd0:  r = '{16'h5601, 6'd1,  6'd1,  1'b1};
      6'd1:  r = '{16'h3401, 6'd2,  6'd6,  1'b0};
      6'd2:  r = '{16'h1801, 6'd3,  6'd9,  1'b0};
      6'd3:  r = '{16'h0AC1, 6'd4,  6'd12, 1'b0};
      6'd4:  r = '{16'h0521, 6'd5,  6'd29, 1'b0};
      6'd5:  r = '{16'h0221, 6'd38, 6'd33, 1'b0};
      6'd6:  r = '{16'h5601, 6'd7,  6'd6,  1'b1};
      6'd7:  r = '{16'h5401, 6'd8,  6'd14, 1'b0};
      6'd8:  r = '{16'h4801, 6'd9,  6'd14, 1'b0};
      6'd9:  r = '{16'h3801, 6'd10, 6'd14, 1'b0};
      6'd10: r = '{16'h3001, 6'd11, 6'd17, 1'b0};
      6'd11: r = '{16'h2401, 6'd12, 6'd18, 1'b0};
      6'd12: r = '{16'h1C01, 6'd13, 6'd20, 1'b0};
      6'd13: r = '{16'h1601, 6'd29, 6'd21, 1'b0};
      6'd14: r = '{16'h5601, 6'd15, 6'd14, 1'b1};
      6'd15: r = '{16'h5401, 6'd16, 6'd14, 1'b0};
      6'd16: r = '{16'h5101, 6'd17, 6'd15, 1'b0};
      6'd17: r = '{16'h4801, 6'd18, 6'd16, 1'b0};
      6'd18: r = '{16'h3801, 6'd19, 6'd17, 1'b0};
      6'd19: r = '{16'h3401, 6'd20, 6'd18, 1'b0};
      6'd20: r = '{16'h3001, 6'd21, 6'd19, 1'b0};
      6'd21: r = '{16'h2801, 6'd22, 6'd19, 1'b0};
      6'd22: r = '{16'h2401, 6'd23, 6'd20, 1'b0};
      6'd23: r = '{16'h2201, 6'd24, 6'd21, 1'b0};
      6'd24: r = '{16'h1C01, 6'd25, 6'd22, 1'b0};
      6'd25: r = '{16'h1801, 6'd26, 6'd23, 1'b0};
      6'd26: r = '{16'h1601, 6'd27, 6'd24, 1'b0};
      6'd27: r = '{16'h1401, 6'd28, 6'd25, 1'b0};
      6'd28: r = '{16'h1201, 6'd29, 6'd26, 1'b0};
      6'd29: r = '{16'h1101, 6'd30, 6'd27, 1'b0};
      6'd30: r = '{16'h0AC1, 6'd31, 6'd28, 1'b0};
      6'd31: r = '{16'h09C1, 6'd32, 6'd29, 1'b0};
      6'd32: r = '{16'h08A1, 6'd33, 6'd30, 1'b0};
      6'd33: r = '{16'h0521, 6'd34, 6'd31, 1'b0};
      6'd34: r = '{16'h0441, 6'd35, 6'd32, 1'b0};
      6'd35: r = '{16'h02A1, 6'd36, 6'd33, 1'b0};
      6'd36: r = '{16'h0221, 6'd37, 6'd34, 1'b0};
      6'd37: r = '{16'h0141, 6'd38, 6'd35, 1'b0};
      6'd38: r = '{16'h0111, 6'd39, 6'd36, 1'b0};
      6'd39: r = '{16'h0085, 6'd40, 6'd37, 1'b0};
      6'd40: r = '{16'h0049, 6'd41, 6'd38, 1'b0};
      6'd41: r = '{16'h0025, 6'd42, 6'd39, 1'b0};
      6'd42: r = '{16'h0015, 6'd43, 6'd40, 1'b0};
      6'd43: r = '{16'h0009, 6'd44, 6'd41, 1'b0};
      6'd44: r = '{16'h0005, 6'd45, 6'd42, 1'b0};
      6'd45: r = '{16'h0001, 6'd45, 6'd43, 1'b0};
      default: r = '{16'h5601, 6'd46, 6'd46, 1'b0};
    endcase
    return r;
  endfunction

endpackage

/* hdl/mq_arithmetic_decoder.sv */
// MQ arithmetic decoder with 19 adaptive contexts and the standard 47-row
// probability table. Each input transaction carries a function: clear the
// segment buffer, append one coded byte, initialise decoding, or decode one
// bit in context context_req_i. Only a decode produces an output transaction
// (decoded_bit_o, past_end_o). Clear and append finish in the accepting cycle.
// Initialise steps through context reset, two reads of the segment memory
// and code register priming. A decode without renormalization goes from the
// decision step straight to the output; otherwise it shifts the interval one
// bit per cycle and fetches a byte from the memory through the read states
// whenever the bit counter runs out, with the memory read registered.
// The block takes one transaction at a time. The output register holds one
// result, so new transactions are taken while it waits; a finished decode
// holds in its last cycle (and keeps in_stall_o high) only while the previous
// result is still stalled. Bytes past the loaded length read as 0xFF;
// appends beyond MAX_SEGMENT_BYTES are dropped.
module mq_arithmetic_decoder #(
  parameter int unsigned MAX_SEGMENT_BYTES = mqd_pkg::MaxSegmentBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [7:0] data_byte_i,
  input  logic [4:0] context_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       decoded_bit_o,
  output logic       past_end_o
);
  import mqd_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  state_e state;

  mqd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  mqd_datapath #(
    .MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_byte_i   (data_byte_i),
    .context_req_i (context_req_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .decoded_bit_o (decoded_bit_o),
    .past_end_o    (past_end_o)
  );

  // Initialise and decode transactions keep the block busy the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == FUNC_INIT || func_i == FUNC_DECODE)
    |=> in_stall_o)
    else $error("block not busy after init/decode transaction");

  // A decode result never appears in the cycle right after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == FUNC_DECODE |=> !$rose(out_valid_o))
    else $error("result shown too early");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i
    |=> out_valid_o && $stable(decoded_bit_o) && $stable(past_end_o))
    else $error("stalled result changed");

  // Output becomes valid only out of the done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state == S_DONE))
    else $error("result without finished decode");

endmodule

/* hdl/mqd_datapath.sv */
module mqd_datapath #(
  parameter int unsigned MAX_SEGMENT_BYTES = mqd_pkg::MaxSegmentBytes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mqd_pkg::cmd_t cmd_i,
  output mqd_pkg::sts_t sts_o,
  input  logic [7:0]    data_byte_i,
  input  logic [4:0]    context_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          decoded_bit_o,
  output logic          past_end_o
);
  import mqd_pkg::*;

  localparam int unsigned AW = (MAX_SEGMENT_BYTES > 1) ? $clog2(MAX_SEGMENT_BYTES) : 1;
  localparam int unsigned PW = $clog2(MAX_SEGMENT_BYTES + 1);
  localparam logic [PW-1:0] MaxLen = PW'(MAX_SEGMENT_BYTES);

  logic [7:0]    mem_q [MAX_SEGMENT_BYTES];
  logic [7:0]    rdata_q;
  logic [7:0]    b0_q;
  logic [PW-1:0] len_q, rp_q;
  logic [31:0]   code_q;
  logic [15:0]   interval_q;
  logic [3:0]    bc_q;
  logic [7:0]    emc_q;
  logic [6:0]    ctx_q [NumContexts];
  logic [4:0]    cx_q;
  logic          bit_q;

  logic [PW:0]   rp_p1;
  logic [AW-1:0] raddr;
  logic [7:0]    nxt;

  assign rp_p1 = {1'b0, rp_q} + 1'b1;
  assign raddr = cmd_i.rd_next ? rp_p1[AW-1:0] : rp_q[AW-1:0];
  assign nxt   = (rp_p1 < {1'b0, len_q}) ? rdata_q : 8'hFF;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && (len_q < MaxLen)) begin
      mem_q[len_q[AW-1:0]] <= data_byte_i;
    end
    rdata_q <= mem_q[raddr];
  end

  // Byte input step
  logic [31:0] base, code_a;
  logic [3:0]  bc_a;
  logic        rp_inc, emc_inc;

  always_comb begin
    base    = cmd_i.apply_init ? {8'd0, b0_q, 16'd0} : code_q;
    code_a  = base;
    bc_a    = 4'd8;
    rp_inc  = 1'b0;
    emc_inc = 1'b0;
    if (b0_q == 8'hFF) begin
      if (nxt > 8'h8F) begin
        code_a  = base + 32'h0000_FF00;
        emc_inc = 1'b1;
      end else begin
        rp_inc = 1'b1;
        code_a = base + {15'd0, nxt, 9'd0};
        bc_a   = 4'd7;
      end
    end else begin
      rp_inc = 1'b1;
      code_a = base + {16'd0, nxt, 8'd0};
    end
  end

  // Decision step
  logic        cx_ok;
  logic [6:0]  ctx_raw, st, to_mps, to_lps, ctx_new;
  prob_row_t   pr;
  logic        mps, dec_bit, dec_renorm, ctx_wr, lps_path, cond;
  logic [15:0] inew, int_new;
  logic [31:0] code_new;

  assign cx_ok = (cx_q < 5'(NumContexts));

  always_comb begin
    ctx_raw    = cx_ok ? ctx_q[cx_q] : 7'd0;
    st         = (ctx_raw >= 7'd94) ? ctx_raw - 7'd94 : ctx_raw;
    mps        = st[0];
    pr         = prob_row(st[6:1]);
    to_mps     = {pr.next_mps, mps};
    to_lps     = {pr.next_lps, mps ^ pr.flip};
    inew       = interval_q - pr.qe;
    lps_path   = code_q[31:16] < pr.qe;
    cond       = inew < pr.qe;
    code_new   = code_q;
    int_new    = inew;
    dec_bit    = mps;
    ctx_new    = to_mps;
    ctx_wr     = 1'b0;
    dec_renorm = 1'b0;
    if (lps_path) begin
      dec_bit    = cond ? mps : ~mps;
      ctx_new    = cond ? to_mps : to_lps;
      ctx_wr     = 1'b1;
      int_new    = pr.qe;
      dec_renorm = 1'b1;
    end else begin
      code_new = code_q - {pr.qe, 16'd0};
      if (!inew[15]) begin
        dec_bit    = cond ? ~mps : mps;
        ctx_new    = cond ? to_lps : to_mps;
        ctx_wr     = 1'b1;
        dec_renorm = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      rp_q        <= '0;
      code_q      <= '0;
      interval_q  <= 16'h8000;
      bc_q        <= '0;
      emc_q       <= '0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < NumContexts; i++) ctx_q[i] <= '0;
    end else begin
      if (cmd_i.clear) len_q <= '0;
      if (cmd_i.append && (len_q < MaxLen)) len_q <= len_q + 1'b1;
      if (cmd_i.init_regs) begin
        for (int i = 0; i < NumContexts; i++) begin
          if (i == 18) ctx_q[i] <= 7'd92;
          else if (i == 17) ctx_q[i] <= 7'd6;
          else if (i == 0) ctx_q[i] <= 7'd8;
          else ctx_q[i] <= '0;
        end
        rp_q      <= '0;
        emc_q     <= '0;
      end
      if (cmd_i.apply) begin
        if (rp_inc) rp_q <= rp_q + 1'b1;
        if (emc_inc && (emc_q != 8'hFF)) emc_q <= emc_q + 1'b1;
        if (cmd_i.apply_init) begin
          code_q     <= code_a << 7;
          bc_q       <= bc_a - 4'd7;
          interval_q <= 16'h8000;
        end else begin
          code_q <= code_a;
          bc_q   <= bc_a;
        end
      end
      if (cmd_i.decode && cx_ok) begin
        code_q     <= code_new;
        interval_q <= int_new;
        if (ctx_wr) ctx_q[cx_q] <= ctx_new;
      end
      if (cmd_i.shift) begin
        interval_q <= interval_q << 1;
        code_q     <= code_q << 1;
        bc_q       <= bc_q - 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) cx_q <= context_req_i;
    if (cmd_i.capture_b0) b0_q <= (rp_q < len_q) ? rdata_q : 8'hFF;
    if (cmd_i.decode) bit_q <= cx_ok & dec_bit;
    if (cmd_i.load_out) begin
      decoded_bit_o <= bit_q;
      past_end_o    <= (emc_q != 8'd0);
    end
  end

  assign sts_o.cx_ok      = cx_ok;
  assign sts_o.dec_renorm = dec_renorm;
  assign sts_o.bc_zero    = (bc_q == 4'd0);
  assign sts_o.shift_done = interval_q[14];
  assign sts_o.out_busy   = out_valid_o && out_stall_i;

endmodule

/* hdl/mqd_ctrl.sv */
module mqd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      func_i,
  input  mqd_pkg::sts_t   sts_i,
  output mqd_pkg::cmd_t   cmd_o,
  output mqd_pkg::state_e state_o
);
  import mqd_pkg::*;

  state_e state_q, state_d;
  logic   init_mode_q;
  logic   accept;
  func_e  func;

  assign func       = func_e'(func_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign state_o    = state_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && func == FUNC_INIT) state_d = S_INIT;
        else if (accept && func == FUNC_DECODE) state_d = S_DEC;
      end
      S_INIT:  state_d = S_RD0;
      S_RD0:   state_d = S_RD1;
      S_RD1:   state_d = S_APPLY;
      S_APPLY: state_d = init_mode_q ? S_IDLE : S_REN;
      S_DEC:   state_d = (sts_i.cx_ok && sts_i.dec_renorm) ? S_REN : S_DONE;
      S_REN: begin
        if (sts_i.bc_zero) state_d = S_RD0;
        else if (sts_i.shift_done) state_d = S_DONE;
      end
      S_DONE:  state_d = sts_i.out_busy ? S_DONE : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = accept;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.clear  = accept && (func == FUNC_CLEAR);
        cmd_o.append = accept && (func == FUNC_APPEND);
      end
      S_INIT:  cmd_o.init_regs = 1'b1;
      S_RD0:   cmd_o.rd_next = 1'b0;
      S_RD1: begin
        cmd_o.rd_next    = 1'b1;
        cmd_o.capture_b0 = 1'b1;
      end
      S_APPLY: begin
        cmd_o.apply      = 1'b1;
        cmd_o.apply_init = init_mode_q;
      end
      S_DEC:   cmd_o.decode = 1'b1;
      S_REN:   cmd_o.shift = !sts_i.bc_zero;
      S_DONE:  cmd_o.load_out = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      init_mode_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_INIT) init_mode_q <= 1'b1;
      else if (state_q == S_DEC) init_mode_q <= 1'b0;
    end
  end

endmodule
